FILE: rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the motor encoder feedback tracker
// Widths of the frame and result fields, register indexes, config bundle.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int unsigned MOTORS          = 8;
  localparam int unsigned IDX_W           = $clog2(MOTORS);
  localparam int unsigned ANGLE_W         = 13;
  localparam int unsigned COUNTS_PER_TURN = 1 << ANGLE_W;
  localparam int unsigned HALF_TURN       = COUNTS_PER_TURN / 2;
  localparam int unsigned ID_W            = 11;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned FRAMES_W        = 8;
  localparam int unsigned REV_W           = 32;
  localparam int unsigned SPEED_W         = 16;
  localparam int unsigned CURR_W          = 16;
  localparam int unsigned TEMP_W          = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 11;

  localparam logic [ID_W-1:0]     BASE_ID_RST       = 11'd513;
  localparam logic [CNT_W-1:0]    MOTOR_COUNT_RST   = 4'd7;
  localparam logic [FRAMES_W-1:0] OFFSET_FRAMES_RST = 8'd50;
  localparam logic [CNT_W-1:0]    MOTORS_LIMIT      = CNT_W'(MOTORS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ID       = 2'd0,
    REG_MOTOR_COUNT   = 2'd1,
    REG_OFFSET_FRAMES = 2'd2
  } met_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]     base_id;
    logic [CNT_W-1:0]    motor_count;
    logic [FRAMES_W-1:0] offset_frames;
  } met_cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]           frame_id;
    logic [ANGLE_W-1:0]        encoder_angle;
    logic signed [SPEED_W-1:0] motor_speed;
    logic signed [CURR_W-1:0]  motor_current;
    logic [TEMP_W-1:0]         temperature;
  } met_frame_t;

  typedef struct packed {
    logic                      accepted;
    logic [IDX_W-1:0]          motor_index;
    logic                      calibrating;
    logic [ANGLE_W-1:0]        angle_out;
    logic signed [REV_W-1:0]   revolutions;
    logic signed [REV_W-1:0]   position_out;
    logic signed [SPEED_W-1:0] speed_out;
    logic signed [CURR_W-1:0]  current_out;
    logic [TEMP_W-1:0]         temperature_out;
  } met_result_t;

endpackage

FILE: rtl/met_if.sv
// ----------------------------------------------------------------------------
// met interfaces: feedback frame, result and configuration channels
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface met_in_if;
  logic                               valid;
  logic                               ready;
  logic [met_pkg::ID_W-1:0]           frame_id;
  logic [met_pkg::ANGLE_W-1:0]        encoder_angle;
  logic signed [met_pkg::SPEED_W-1:0] motor_speed;
  logic signed [met_pkg::CURR_W-1:0]  motor_current;
  logic [met_pkg::TEMP_W-1:0]         temperature;

  modport source (output valid, frame_id, encoder_angle, motor_speed, motor_current,
                  temperature, input ready);
  modport sink (input valid, frame_id, encoder_angle, motor_speed, motor_current,
                temperature, output ready);
endinterface

interface met_out_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic [met_pkg::IDX_W-1:0]          motor_index;
  logic                               calibrating;
  logic [met_pkg::ANGLE_W-1:0]        angle_out;
  logic signed [met_pkg::REV_W-1:0]   revolutions;
  logic signed [met_pkg::REV_W-1:0]   position_out;
  logic signed [met_pkg::SPEED_W-1:0] speed_out;
  logic signed [met_pkg::CURR_W-1:0]  current_out;
  logic [met_pkg::TEMP_W-1:0]         temperature_out;

  modport source (output valid, accepted, motor_index, calibrating, angle_out, revolutions,
                  position_out, speed_out, current_out, temperature_out, input ready);
  modport sink (input valid, accepted, motor_index, calibrating, angle_out, revolutions,
                position_out, speed_out, current_out, temperature_out, output ready);
endinterface

interface met_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [met_pkg::CFG_IDX_W-1:0]      index;
  logic [met_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/met_cfg_regs.sv
// ----------------------------------------------------------------------------
// met_cfg_regs: configuration register file
// Holds base id, motor count and offset frame count; always ready.
// ----------------------------------------------------------------------------
module met_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  met_cfg_if.sink          cfg_i,
  output met_pkg::met_cfg_t cfg_o
);

  met_pkg::met_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        met_pkg::REG_BASE_ID:       cfg_d.base_id = cfg_i.data[met_pkg::ID_W-1:0];
        met_pkg::REG_MOTOR_COUNT:   cfg_d.motor_count = cfg_i.data[met_pkg::CNT_W-1:0];
        met_pkg::REG_OFFSET_FRAMES: cfg_d.offset_frames = cfg_i.data[met_pkg::FRAMES_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_id       <= met_pkg::BASE_ID_RST;
      cfg_q.motor_count   <= met_pkg::MOTOR_COUNT_RST;
      cfg_q.offset_frames <= met_pkg::OFFSET_FRAMES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/met_track.sv
// ----------------------------------------------------------------------------
// met_track: per-motor state and single-pass update
// Decodes the motor entry, computes the result and commits the entry on upd_i.
// ----------------------------------------------------------------------------
module met_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  met_pkg::met_cfg_t    cfg_i,
  input  met_pkg::met_frame_t  frame_i,
  output met_pkg::met_result_t res_o
);

  localparam int unsigned DIFF_W = met_pkg::ANGLE_W + 1;
  localparam int unsigned SHL_W  = met_pkg::REV_W - met_pkg::ANGLE_W;

  logic [met_pkg::ANGLE_W-1:0]  angle_q  [met_pkg::MOTORS];
  logic [met_pkg::ANGLE_W-1:0]  offset_q [met_pkg::MOTORS];
  logic [met_pkg::REV_W-1:0]    turn_q   [met_pkg::MOTORS];
  logic [met_pkg::REV_W-1:0]    pos_q    [met_pkg::MOTORS];
  logic [met_pkg::FRAMES_W-1:0] fcnt_q   [met_pkg::MOTORS];

  logic [met_pkg::CNT_W-1:0]    limit;
  logic [met_pkg::ID_W-1:0]     rel_id;
  logic                         hit;
  logic [met_pkg::IDX_W-1:0]    idx;
  logic                         calib;
  logic signed [DIFF_W-1:0]     diff;
  logic [met_pkg::REV_W-1:0]    turn_new;
  logic [met_pkg::REV_W-1:0]    pos_new;
  logic [met_pkg::ANGLE_W-1:0]  ang;

  always_comb begin
    limit  = (cfg_i.motor_count > met_pkg::MOTORS_LIMIT) ? met_pkg::MOTORS_LIMIT
                                                         : cfg_i.motor_count;
    rel_id = frame_i.frame_id - cfg_i.base_id;
    hit    = (frame_i.frame_id >= cfg_i.base_id) &&
             (rel_id < {{(met_pkg::ID_W-met_pkg::CNT_W){1'b0}}, limit});
    idx    = rel_id[met_pkg::IDX_W-1:0];
    ang    = frame_i.encoder_angle;
    calib  = fcnt_q[idx] <= cfg_i.offset_frames;
    diff   = $signed({1'b0, ang}) - $signed({1'b0, angle_q[idx]});
    if (diff > $signed(DIFF_W'(met_pkg::HALF_TURN))) begin
      turn_new = turn_q[idx] - 32'd1;
    end else if (diff < -$signed(DIFF_W'(met_pkg::HALF_TURN))) begin
      turn_new = turn_q[idx] + 32'd1;
    end else begin
      turn_new = turn_q[idx];
    end
    pos_new = {turn_new[SHL_W-1:0], {met_pkg::ANGLE_W{1'b0}}}
              + {{SHL_W{1'b0}}, ang} - {{SHL_W{1'b0}}, offset_q[idx]};

    res_o = '0;
    if (hit) begin
      res_o.accepted        = 1'b1;
      res_o.motor_index     = idx;
      res_o.calibrating     = calib;
      res_o.angle_out       = ang;
      res_o.revolutions     = calib ? turn_q[idx] : turn_new;
      res_o.position_out    = calib ? pos_q[idx] : pos_new;
      res_o.speed_out       = frame_i.motor_speed;
      res_o.current_out     = frame_i.motor_current;
      res_o.temperature_out = frame_i.temperature;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < met_pkg::MOTORS; i++) begin
        angle_q[i]  <= '0;
        offset_q[i] <= '0;
        turn_q[i]   <= '0;
        pos_q[i]    <= '0;
        fcnt_q[i]   <= '0;
      end
    end else if (upd_i && hit) begin
      angle_q[idx] <= ang;
      if (fcnt_q[idx] != {met_pkg::FRAMES_W{1'b1}}) begin
        fcnt_q[idx] <= fcnt_q[idx] + 8'd1;
      end
      if (calib) begin
        offset_q[idx] <= ang;
      end else begin
        turn_q[idx] <= turn_new;
        pos_q[idx]  <= pos_new;
      end
    end
  end

endmodule

FILE: rtl/motor_encoder_feedback_tracker.sv
// ----------------------------------------------------------------------------
// motor_encoder_feedback_tracker: multi-turn position tracking for 8 motors
// Path: each input beat passes the input register, then the result register.
// Throughput: one frame per cycle while the result channel is not stalled; the
// per-motor read-modify-write is combinational between the two registers.
// Reset: all per-motor state clears to zero, registers return to defaults.
// ----------------------------------------------------------------------------
module motor_encoder_feedback_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  met_cfg_if.sink   cfg_i,
  met_in_if.sink    in_i,
  met_out_if.source out_o
);

  met_pkg::met_cfg_t    cfg;
  met_pkg::met_frame_t  frame_d, frame_q;
  met_pkg::met_result_t res, res_q;

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv;   // result register free or draining this cycle
  logic s1_adv;    // input register moves into the result register
  logic in_fire;

  met_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Per-motor state commits exactly when its frame advances to the output.
  met_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (s1_adv),
    .cfg_i   (cfg),
    .frame_i (frame_q),
    .res_o   (res)
  );

  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    frame_d.frame_id      = in_i.frame_id;
    frame_d.encoder_angle = in_i.encoder_angle;
    frame_d.motor_speed   = in_i.motor_speed;
    frame_d.motor_current = in_i.motor_current;
    frame_d.temperature   = in_i.temperature;
  end

  // Hold the input beat until the result register can take it.
  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= frame_d;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = res_q.accepted;
  assign out_o.motor_index     = res_q.motor_index;
  assign out_o.calibrating     = res_q.calibrating;
  assign out_o.angle_out       = res_q.angle_out;
  assign out_o.revolutions     = res_q.revolutions;
  assign out_o.position_out    = res_q.position_out;
  assign out_o.speed_out       = res_q.speed_out;
  assign out_o.current_out     = res_q.current_out;
  assign out_o.temperature_out = res_q.temperature_out;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of motor_encoder_feedback_tracker
// Drives feedback frames and register writes over valid/ready channels, tracks
// each motor entry in a behavioral copy of the block, and compares every result
// beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import met_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;       // result path is two registers deep
  localparam int unsigned CYCLE_LIMIT  = 500000;  // several times the slowest clean run

  logic clk_i = 1'b0;
  logic rst_ni;

  met_cfg_if cfg_if ();
  met_in_if  in_if ();
  met_out_if out_if ();

  motor_encoder_feedback_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copies as the block should hold them
  logic [ID_W-1:0]     trk_base;
  logic [CNT_W-1:0]    trk_count;
  logic [FRAMES_W-1:0] trk_offset_frames;

  // Per-motor tracking state
  logic [ANGLE_W-1:0]  trk_angle  [MOTORS];
  logic [ANGLE_W-1:0]  trk_prev   [MOTORS];
  logic [ANGLE_W-1:0]  trk_zero   [MOTORS];
  logic [REV_W-1:0]    trk_turns  [MOTORS];
  logic [REV_W-1:0]    trk_total  [MOTORS];
  logic [FRAMES_W-1:0] trk_frames [MOTORS];

  // Angle trajectory that the stimulus follows for each entry
  logic [ANGLE_W-1:0]  walk_angle [MOTORS];

  met_result_t pending_results[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          result_taken = 1'b0;
  int unsigned sink_hold    = 0;

  // Advance one motor entry by one frame and return the result it must produce.
  function automatic met_result_t track_frame(input met_frame_t f);
    met_result_t r;
    int unsigned span;
    int unsigned slot;
    int          delta;
    logic        calib;
    r    = '0;
    span = (trk_count < MOTORS) ? trk_count : MOTORS;
    // Ids outside the window leave every entry alone and report all zeros
    if (f.frame_id < trk_base) return r;
    slot = f.frame_id - trk_base;
    if (slot >= span) return r;

    // Compare the counter before it moves; saturate it at its top value
    calib = (trk_frames[slot] <= trk_offset_frames);
    if (trk_frames[slot] != '1) trk_frames[slot]++;

    if (calib) begin
      // Capture the zero offset; turns and total hold their old values
      trk_angle[slot] = f.encoder_angle;
      trk_zero[slot]  = f.encoder_angle;
    end else begin
      trk_prev[slot]  = trk_angle[slot];
      trk_angle[slot] = f.encoder_angle;
      delta = int'(f.encoder_angle) - int'(trk_prev[slot]);
      // A jump of more than half a turn means the encoder wrapped
      if (delta > int'(HALF_TURN)) begin
        trk_turns[slot] = trk_turns[slot] - 1;
      end else if (delta < -int'(HALF_TURN)) begin
        trk_turns[slot] = trk_turns[slot] + 1;
      end
      trk_total[slot] = trk_turns[slot] * COUNTS_PER_TURN + f.encoder_angle - trk_zero[slot];
    end

    r.accepted        = 1'b1;
    r.motor_index     = IDX_W'(slot);
    r.calibrating     = calib;
    r.angle_out       = trk_angle[slot];
    r.revolutions     = trk_turns[slot];
    r.position_out    = trk_total[slot];
    r.speed_out       = f.motor_speed;
    r.current_out     = f.motor_current;
    r.temperature_out = f.temperature;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watch both data channels at the rising edge: predict on each frame beat,
  // check each result beat against the oldest prediction.
  always @(posedge clk_i) begin : beat_monitor
    met_frame_t  f;
    met_result_t got;
    met_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("motor_encoder_feedback_tracker verification failed");
      $finish;
    end
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        f.frame_id      = in_if.frame_id;
        f.encoder_angle = in_if.encoder_angle;
        f.motor_speed   = in_if.motor_speed;
        f.motor_current = in_if.motor_current;
        f.temperature   = in_if.temperature;
        pending_results.push_back(track_frame(f));
      end
      if (out_if.valid && out_if.ready) begin
        result_taken        = 1'b1;
        got.accepted        = out_if.accepted;
        got.motor_index     = out_if.motor_index;
        got.calibrating     = out_if.calibrating;
        got.angle_out       = out_if.angle_out;
        got.revolutions     = out_if.revolutions;
        got.position_out    = out_if.position_out;
        got.speed_out       = out_if.speed_out;
        got.current_out     = out_if.current_out;
        got.temperature_out = out_if.temperature_out;
        if (pending_results.size() == 0) begin
          $error("result beat with no frame outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("motor_index", want.motor_index, got.motor_index);
          check_field("calibrating", want.calibrating, got.calibrating);
          check_field("angle_out", want.angle_out, got.angle_out);
          check_field("revolutions", want.revolutions, got.revolutions);
          check_field("position_out", want.position_out, got.position_out);
          check_field("speed_out", want.speed_out, got.speed_out);
          check_field("current_out", want.current_out, got.current_out);
          check_field("temperature_out", want.temperature_out, got.temperature_out);
        end
      end
    end
  end

  // Result receiver: after each beat draw a stall, and honor any long hold-off
  // requested by a test while the sender keeps offering frames.
  initial begin : result_sink
    int unsigned pause;
    pause        = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (result_taken) begin
        pause        = sink_idle_on ? $urandom_range(0, 16) : 0;
        result_taken = 1'b0;
      end
      if (sink_hold != 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else if (pause != 0) begin
        out_if.ready <= 1'b0;
        pause--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one frame after a random gap; return at the falling edge after its beat.
  task automatic send_frame(input met_frame_t f);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.frame_id      <= f.frame_id;
    in_if.encoder_angle <= f.encoder_angle;
    in_if.motor_speed   <= f.motor_speed;
    in_if.motor_current <= f.motor_current;
    in_if.temperature   <= f.temperature;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic met_frame_t make_frame(input logic [ID_W-1:0] id,
                                            input logic [ANGLE_W-1:0] angle);
    met_frame_t f;
    f.frame_id      = id;
    f.encoder_angle = angle;
    f.motor_speed   = SPEED_W'($urandom);
    f.motor_current = CURR_W'($urandom);
    f.temperature   = TEMP_W'($urandom);
    return f;
  endfunction

  // Drop valid and let every outstanding result come back.
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input met_reg_e which, input int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= which;
    cfg_if.data  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (which)
      REG_BASE_ID:       trk_base          = ID_W'(value);
      REG_MOTOR_COUNT:   trk_count         = CNT_W'(value);
      REG_OFFSET_FRAMES: trk_offset_frames = FRAMES_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned base, input int unsigned count,
                                input int unsigned offset);
    drain();
    write_reg(REG_BASE_ID, base);
    write_reg(REG_MOTOR_COUNT, count);
    write_reg(REG_OFFSET_FRAMES, offset);
  endtask

  // Register defaults, window edges and payload extremes.
  task automatic test_reset_defaults;
    send_frame(met_frame_t'{11'd512, 13'd8191, 16'sh7fff, 16'sh8000, 8'hff});
    send_frame(met_frame_t'{11'd513, 13'd0, 16'sh8000, 16'sh7fff, 8'hff});
    send_frame(met_frame_t'{11'd519, 13'd8191, 16'sh7fff, 16'sh8000, 8'h00});
    send_frame(met_frame_t'{11'd520, 13'd4096, 16'sh0000, 16'sh0000, 8'h80});
    send_frame(met_frame_t'{11'd2047, 13'd1, 16'shffff, 16'shffff, 8'h01});
    send_frame(met_frame_t'{11'd0, 13'd2, 16'sh0001, 16'sh0001, 8'hfe});
  endtask

  // Wrap detection around the half-turn boundaries on an untouched entry.
  task automatic test_turn_wrap;
    apply_settings(513, 7, 0);
    send_frame(make_frame(11'd514, 13'd100));   // calibration frame
    send_frame(make_frame(11'd514, 13'd8000));  // backward wrap
    send_frame(make_frame(11'd514, 13'd100));   // forward wrap
    send_frame(make_frame(11'd514, 13'd4196));  // exactly half a turn up: no wrap
    send_frame(make_frame(11'd514, 13'd100));   // exactly half a turn down: no wrap
    send_frame(make_frame(11'd514, 13'd4197));
    send_frame(make_frame(11'd514, 13'd100));
    send_frame(make_frame(11'd514, 13'd0));
    send_frame(make_frame(11'd514, 13'd8191));
    send_frame(make_frame(11'd513, 13'd8191));  // entry 0 now past its calibration frames
  endtask

  // Empty window, oversize count, window running off the top of the id space.
  task automatic test_id_range;
    apply_settings(513, 0, 0);
    send_frame(make_frame(11'd513, 13'd5));
    apply_settings(2040, 15, 0);
    send_frame(make_frame(11'd2047, 13'd6000));
    send_frame(make_frame(11'd2039, 13'd7));
    apply_settings(2047, 8, 0);
    send_frame(make_frame(11'd2047, 13'd300));
    apply_settings(0, 8, 0);
    send_frame(make_frame(11'd0, 13'd8));
    send_frame(make_frame(11'd7, 13'd9));
    send_frame(make_frame(11'd8, 13'd10));
  endtask

  // Run one entry past counter saturation, then capture on every frame.
  task automatic test_counter_saturation;
    int unsigned base;
    base = $urandom_range(0, 2040);
    apply_settings(base, 8, 254);
    for (int i = 0; i < 300; i++) begin
      send_frame(make_frame(ID_W'(base + 7), ANGLE_W'($urandom)));
    end
    apply_settings(base, 8, 255);
    for (int i = 0; i < 20; i++) begin
      send_frame(make_frame(ID_W'(base + 7), ANGLE_W'($urandom)));
    end
  endtask

  // Mostly in-window frames that follow a random angle walk per entry, with
  // jumps and out-of-window noise mixed in.
  task automatic run_tracking_phase(input int unsigned base, input int unsigned count,
                                    input int unsigned offset, input int unsigned items,
                                    input bit src_idle, input bit sink_idle,
                                    input int unsigned hold);
    int unsigned span;
    int unsigned slot;
    apply_settings(base, count, offset);
    src_idle_on  = src_idle;
    sink_idle_on = sink_idle;
    span = (count < MOTORS) ? count : MOTORS;
    for (int i = 0; i < items; i++) begin
      if (hold != 0 && i == items / 3) sink_hold = hold;
      if (span != 0 && $urandom_range(0, 9) < 8) begin
        slot = $urandom_range(0, span - 1);
        if ($urandom_range(0, 4) == 0) begin
          walk_angle[slot] = ANGLE_W'($urandom);
        end else begin
          walk_angle[slot] = walk_angle[slot] + ANGLE_W'($urandom_range(0, 3000))
                             - ANGLE_W'(1500);
        end
        send_frame(make_frame(ID_W'(base + slot), walk_angle[slot]));
      end else begin
        send_frame(make_frame(ID_W'($urandom), ANGLE_W'($urandom)));
      end
    end
  endtask

  task automatic test_random_tracking;
    run_tracking_phase($urandom_range(0, 2040), 8, 0, 210, 1'b1, 1'b1, 0);
    run_tracking_phase(513, 1, 3, 210, 1'b1, 1'b0, 0);
    run_tracking_phase($urandom_range(0, 2047), 15, $urandom_range(0, 10), 210,
                       1'b0, 1'b0, 0);
    run_tracking_phase(2044, 8, 0, 210, 1'b0, 1'b1, 250);
    run_tracking_phase($urandom_range(0, 2047), $urandom_range(0, 15),
                       $urandom_range(0, 254), 210, 1'b1, 1'b1, 0);
    run_tracking_phase(0, 8, 50, 210, 1'b1, 1'b1, 200);
  endtask

  initial begin : test_sequence
    trk_base          = BASE_ID_RST;
    trk_count         = MOTOR_COUNT_RST;
    trk_offset_frames = OFFSET_FRAMES_RST;
    for (int m = 0; m < MOTORS; m++) begin
      trk_angle[m]  = '0;
      trk_prev[m]   = '0;
      trk_zero[m]   = '0;
      trk_turns[m]  = '0;
      trk_total[m]  = '0;
      trk_frames[m] = '0;
      walk_angle[m] = '0;
    end
    // Hold every input at a known value from time zero
    rst_ni               = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_BASE_ID;
    cfg_if.data          = '0;
    in_if.valid          = 1'b0;
    in_if.frame_id       = '0;
    in_if.encoder_angle  = '0;
    in_if.motor_speed    = '0;
    in_if.motor_current  = '0;
    in_if.temperature    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_turn_wrap();
    test_id_range();
    test_counter_saturation();
    test_random_tracking();
    drain();

    if (mismatches == 0) begin
      $display("motor_encoder_feedback_tracker verification clean");
    end else begin
      $display("motor_encoder_feedback_tracker verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/met_pkg.sv
rtl/met_if.sv
rtl/met_cfg_regs.sv
rtl/met_track.sv
rtl/motor_encoder_feedback_tracker.sv
tb/tb_top.sv
